[design/assert_macros.svh]
// assertion macros shared by the spectrum smoother rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SBSPH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define SBSPH_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[design/sbsph_pkg.sv]
// shared types and constants of the spectrum bin smoother
`default_nettype none

package sbsph_pkg;

   localparam int RSSI_LOW   = -100;
   localparam int RSSI_HIGH  = -30;
   localparam int RSSI_SPAN  = RSSI_HIGH - RSSI_LOW;

   localparam logic signed [7:0] BEST_RESET = -8'sd127;

   localparam int GAIN_W     = 9;
   localparam int DECAY_W    = 8;
   localparam logic [GAIN_W-1:0] GAIN_UNITY = 9'd256;

   localparam logic [GAIN_W-1:0]  ATTACK_RESET  = 9'd102;
   localparam logic [GAIN_W-1:0]  RELEASE_RESET = 9'd36;
   localparam logic [DECAY_W-1:0] DECAY_RESET   = 8'd2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_ATTACK_GAIN  = 2'd0;
   localparam logic [1:0] REG_RELEASE_GAIN = 2'd1;
   localparam logic [1:0] REG_PEAK_DECAY   = 2'd2;

   typedef struct packed {
      logic [GAIN_W-1:0]  attack_gain;
      logic [GAIN_W-1:0]  release_gain;
      logic [DECAY_W-1:0] peak_decay_step;
   } csr_cfg_type;

   typedef struct packed {
      logic [15:0] smoothed;
      logic [7:0]  peak;
   } bin_state_type;

endpackage

`default_nettype wire

[design/sbsph_csr.sv]
// configuration register file behind the apb-style port
`default_nettype none

module sbsph_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [sbsph_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [sbsph_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [sbsph_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                    csr_pready,
   output sbsph_pkg::csr_cfg_type                  cfg
);

   sbsph_pkg::csr_cfg_type cfg_ff, cfg_in;
   logic [1:0] reg_sel;
   logic       wr_stb;

   assign reg_sel    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign wr_stb     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         case (reg_sel)
            sbsph_pkg::REG_ATTACK_GAIN:  cfg_in.attack_gain  = csr_pwdata[sbsph_pkg::GAIN_W-1:0];
            sbsph_pkg::REG_RELEASE_GAIN: cfg_in.release_gain = csr_pwdata[sbsph_pkg::GAIN_W-1:0];
            sbsph_pkg::REG_PEAK_DECAY:
               cfg_in.peak_decay_step = csr_pwdata[sbsph_pkg::DECAY_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_gain     <= sbsph_pkg::ATTACK_RESET;
         cfg_ff.release_gain    <= sbsph_pkg::RELEASE_RESET;
         cfg_ff.peak_decay_step <= sbsph_pkg::DECAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         sbsph_pkg::REG_ATTACK_GAIN:
            csr_prdata = sbsph_pkg::CSR_DATA_W'(cfg_ff.attack_gain);
         sbsph_pkg::REG_RELEASE_GAIN:
            csr_prdata = sbsph_pkg::CSR_DATA_W'(cfg_ff.release_gain);
         sbsph_pkg::REG_PEAK_DECAY:
            csr_prdata = sbsph_pkg::CSR_DATA_W'(cfg_ff.peak_decay_step);
         default: csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[design/sbsph_bin_mem.sv]
// per-bin state memory with a clearing sweep after reset and on request
`default_nettype none

module sbsph_bin_mem #(
   parameter int NUM_BINS = 64,
   parameter int AW       = 6
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     clear_start,
   output logic                          clear_busy,
   input  wire logic                     rd_en,
   input  wire logic [AW-1:0]            rd_addr,
   output sbsph_pkg::bin_state_type      rd_data,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire sbsph_pkg::bin_state_type wr_data
);

   sbsph_pkg::bin_state_type mem [NUM_BINS];
   sbsph_pkg::bin_state_type rd_data_ff;
   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_idx_ff, clr_idx_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == AW'(NUM_BINS - 1)) begin
            clr_busy_in = 1'b0;
            clr_idx_in  = '0;
         end
      end else if (clear_start) begin
         clr_busy_in = 1'b1;
         clr_idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // single write port, sweep has priority (no samples enter while it runs)
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

`default_nettype wire

[design/sbsph_bin_calc.sv]
// height scaling, asymmetric smoothing, peak hold and color class of one bin
`default_nettype none

module sbsph_bin_calc #(
   parameter int FULL_HEIGHT = 200
) (
   input  wire logic signed [7:0]        rssi,
   input  wire sbsph_pkg::bin_state_type old_state,
   input  wire sbsph_pkg::csr_cfg_type   cfg,
   output sbsph_pkg::bin_state_type      new_state,
   output logic [7:0]                    bar,
   output logic [1:0]                    color
);

   localparam int HI_LEVEL = FULL_HEIGHT * 6 / 10;
   localparam int LO_LEVEL = FULL_HEIGHT * 3 / 10;

   logic [7:0] height_rom [sbsph_pkg::RSSI_SPAN + 1];

   for (genvar i = 0; i <= sbsph_pkg::RSSI_SPAN; i++) begin : g_height
      localparam int HeightVal = i * FULL_HEIGHT / sbsph_pkg::RSSI_SPAN;
      assign height_rom[i] = 8'(HeightVal);
   end

   logic signed [7:0]  rssi_c;
   logic signed [8:0]  offset_s;
   logic [6:0]         offset;
   logic [7:0]         height;
   logic [15:0]        target;
   logic [sbsph_pkg::GAIN_W-1:0] gain, gain_sat;
   logic signed [16:0] diff;
   logic signed [26:0] prod;
   logic signed [18:0] step;
   logic [19:0]        sum;
   logic [15:0]        sm_new;
   logic [16:0]        rounded;
   logic [7:0]         pk_new;

   always_comb begin
      if (rssi < 8'(sbsph_pkg::RSSI_LOW)) begin
         rssi_c = 8'(sbsph_pkg::RSSI_LOW);
      end else if (rssi > 8'(sbsph_pkg::RSSI_HIGH)) begin
         rssi_c = 8'(sbsph_pkg::RSSI_HIGH);
      end else begin
         rssi_c = rssi;
      end
   end

   assign offset_s = 9'(rssi_c) - 9'(sbsph_pkg::RSSI_LOW);
   assign offset   = offset_s[6:0];
   assign height   = height_rom[offset];
   assign target   = {height, 8'h00};

   // attack when rising, release otherwise; gains above unity act as unity
   assign gain     = (target > old_state.smoothed) ? cfg.attack_gain : cfg.release_gain;
   assign gain_sat = (gain > sbsph_pkg::GAIN_UNITY) ? sbsph_pkg::GAIN_UNITY : gain;

   assign diff = $signed({1'b0, target}) - $signed({1'b0, old_state.smoothed});
   assign prod = diff * $signed({1'b0, gain_sat});
   // dropping the low byte of a two's complement value floors toward minus infinity
   assign step = prod[26:8];
   assign sum  = {4'b0000, old_state.smoothed} + {step[18], step};

   always_comb begin
      if (sum[19]) begin
         sm_new = '0;
      end else if (sum[18:16] != 3'b000) begin
         sm_new = 16'hFFFF;
      end else begin
         sm_new = sum[15:0];
      end
   end

   assign rounded = {1'b0, sm_new} + 17'd128;
   assign bar     = (rounded[16]) ? 8'hFF : rounded[15:8];

   always_comb begin
      if (bar > old_state.peak) begin
         pk_new = bar;
      end else if (old_state.peak >= cfg.peak_decay_step) begin
         pk_new = old_state.peak - cfg.peak_decay_step;
      end else begin
         pk_new = '0;
      end
   end

   always_comb begin
      if (bar > 8'(HI_LEVEL)) begin
         color = 2'd2;
      end else if (bar > 8'(LO_LEVEL)) begin
         color = 2'd1;
      end else begin
         color = 2'd0;
      end
   end

   assign new_state.smoothed = sm_new;
   assign new_state.peak     = pk_new;

endmodule

`default_nettype wire

[design/spectrum_bin_smoother_peak_hold.sv]
// top level of the spectrum bin smoother with peak hold
// Takes one rssi beat per spectrum bin and returns one result beat per input
// beat: the bin's rounded smoothed bar height, its decaying peak hold, a
// three-level color class, and the strongest rssi of the frame so far with
// its bin (first bin to reach it wins). tlast on the input marks the last bin
// of a sweep; it is echoed on the result and resets the frame maximum after
// that beat. tuser = 1 is a clear command: all bins and the frame maximum go
// back to zero / -127 and the result beat reports that cleared state.
// Rate: one beat per clock sustained while results are taken and no clear
// command or sweep holds the input off. A sample beat enters the input
// register at its accept edge, where the bin state read from memory joins it,
// and moves to the result register once that is free. A result that is not
// taken holds the input register, and the input stalls once both are full.
// The per-bin state lives in a single-port-write, registered-read memory of
// NUM_BINS entries. After reset the memory is swept to zero, one entry per
// cycle, so req_tready stays low until all NUM_BINS entries (64 by default)
// are cleared. A clear command holds req_tready low while it sits in the input
// register and then for the whole sweep; the configuration port keeps working
// meanwhile.
// Configuration may only be written while no beat is in flight.
`default_nettype none

`include "assert_macros.svh"

module spectrum_bin_smoother_peak_hold #(
   parameter int NUM_BINS    = 64,   // 2 .. 64
   parameter int FULL_HEIGHT = 200   // 16 .. 255
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input stream
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [15:0]                      req_tdata,  // bin_index[5:0], rssi_dbm[13:6]
   input  wire logic                             req_tuser,  // command
   input  wire logic                             req_tlast,  // last_bin
   // result stream
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // bar_height[7:0], peak_height[15:8], color_level[17:16], best_bin[23:18], max_rssi[31:24]
   output logic [31:0]                           rsp_tdata,
   output logic                                  rsp_tlast,  // frame_done
   // configuration
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [sbsph_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [sbsph_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [sbsph_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                  csr_pready
);

   localparam int AW = (NUM_BINS > 2) ? $clog2(NUM_BINS) : 1;
   localparam int IW = (AW > 6) ? AW : 6;

   sbsph_pkg::csr_cfg_type   cfg;
   sbsph_pkg::bin_state_type rd_state, old_state, new_state;

   // input fields
   logic [5:0]        req_bin;
   logic signed [7:0] req_rssi;
   logic [IW-1:0]     req_bin_ext;
   logic [AW-1:0]     req_addr;
   logic              req_fire;

   // stage 1: accepted beat, memory read data arrives alongside
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_cmd_ff;
   logic [5:0]        s1_bin_ff;
   logic signed [7:0] s1_rssi_ff;
   logic              s1_last_ff;
   logic              s1_adv;
   logic              s1_in_range;
   logic [IW-1:0]     s1_bin_ext;
   logic [AW-1:0]     s1_addr;

   // last memory write, forwarded to a beat that read the same bin at that edge
   logic              fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0]     fwd_addr_ff;
   sbsph_pkg::bin_state_type fwd_data_ff;

   // frame maximum tracking
   logic signed [7:0] max_rssi_ff, max_rssi_in;
   logic [5:0]        best_bin_ff, best_bin_in;
   logic signed [7:0] max_rssi_now;
   logic [5:0]        best_bin_now;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_bar_ff, rsp_peak_ff;
   logic [1:0]        rsp_color_ff;
   logic              rsp_last_ff;
   logic [5:0]        rsp_best_bin_ff;
   logic signed [7:0] rsp_max_rssi_ff;
   logic              out_free;

   logic [7:0]        calc_bar;
   logic [1:0]        calc_color;
   logic              mem_wr_en;
   logic              clear_start;
   logic              clear_busy;

   sbsph_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // unpack input beat
   assign req_bin     = req_tdata[5:0];
   assign req_rssi    = req_tdata[13:6];
   assign req_bin_ext = IW'(req_bin);
   assign req_addr    = req_bin_ext[AW-1:0];

   // handshake: hold off while sweeping, while a clear command waits to leave, and while a full stage cannot move on
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !clear_busy && (!s1_valid_ff || (out_free && !s1_cmd_ff));
   assign req_fire   = req_tvalid && req_tready;
   assign s1_adv     = s1_valid_ff && out_free;

   assign s1_bin_ext  = IW'(s1_bin_ff);
   assign s1_addr     = s1_bin_ext[AW-1:0];
   assign s1_in_range = (int'(s1_bin_ff) < NUM_BINS);

   assign clear_start = s1_adv && s1_cmd_ff;
   assign mem_wr_en   = s1_adv && !s1_cmd_ff && s1_in_range;

   sbsph_bin_mem #(
      .NUM_BINS (NUM_BINS),
      .AW       (AW)
   ) u_bin_mem (
      .clock       (clock),
      .reset       (reset),
      .clear_start (clear_start),
      .clear_busy  (clear_busy),
      .rd_en       (req_fire),
      .rd_addr     (req_addr),
      .rd_data     (rd_state),
      .wr_en       (mem_wr_en),
      .wr_addr     (s1_addr),
      .wr_data     (new_state)
   );

   // the write at the accept edge is not seen by the registered read
   assign old_state = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ? fwd_data_ff : rd_state;

   sbsph_bin_calc #(
      .FULL_HEIGHT (FULL_HEIGHT)
   ) u_bin_calc (
      .rssi      (s1_rssi_ff),
      .old_state (old_state),
      .cfg       (cfg),
      .new_state (new_state),
      .bar       (calc_bar),
      .color     (calc_color)
   );

   // strongest rssi of the frame including this beat
   always_comb begin
      if (s1_rssi_ff > max_rssi_ff) begin
         max_rssi_now = s1_rssi_ff;
         best_bin_now = s1_bin_ff;
      end else begin
         max_rssi_now = max_rssi_ff;
         best_bin_now = best_bin_ff;
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      fwd_valid_in = fwd_valid_ff;
      max_rssi_in  = max_rssi_ff;
      best_bin_in  = best_bin_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_adv) begin
         s1_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         if (s1_cmd_ff || s1_last_ff) begin
            max_rssi_in = sbsph_pkg::BEST_RESET;
            best_bin_in = '0;
         end else begin
            max_rssi_in = max_rssi_now;
            best_bin_in = best_bin_now;
         end
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
      if (mem_wr_en) begin
         fwd_valid_in = 1'b1;
      end
      if (clear_busy) begin
         fwd_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_rssi_ff  <= sbsph_pkg::BEST_RESET;
         best_bin_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         max_rssi_ff  <= max_rssi_in;
         best_bin_ff  <= best_bin_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff  <= req_tuser;
         s1_bin_ff  <= req_bin;
         s1_rssi_ff <= req_rssi;
         s1_last_ff <= req_tlast;
      end
      if (mem_wr_en) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= new_state;
      end
      if (s1_adv) begin
         if (s1_cmd_ff) begin
            rsp_bar_ff      <= '0;
            rsp_peak_ff     <= '0;
            rsp_color_ff    <= '0;
            rsp_last_ff     <= 1'b0;
            rsp_best_bin_ff <= '0;
            rsp_max_rssi_ff <= sbsph_pkg::BEST_RESET;
         end else begin
            rsp_bar_ff      <= s1_in_range ? calc_bar : 8'd0;
            rsp_peak_ff     <= s1_in_range ? new_state.peak : 8'd0;
            rsp_color_ff    <= s1_in_range ? calc_color : 2'd0;
            rsp_last_ff     <= s1_last_ff;
            rsp_best_bin_ff <= best_bin_now;
            rsp_max_rssi_ff <= max_rssi_now;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_max_rssi_ff, rsp_best_bin_ff, rsp_color_ff, rsp_peak_ff, rsp_bar_ff};

   // no beat is taken in while the memory sweep runs
   `SBSPH_NEVER(a_no_accept_in_sweep, clock, reset, clear_busy && req_tready,
                "beat accepted during memory sweep")
   // the input stage is empty for the whole sweep
   `SBSPH_NEVER(a_stage_empty_in_sweep, clock, reset, clear_busy && s1_valid_ff,
                "stage busy during memory sweep")
   // a clear command leaving the stage starts the sweep
   `SBSPH_ASSERT(a_clear_starts_sweep, clock, reset, clear_start |=> clear_busy,
                 "clear did not start sweep")
   // a beat leaving the stage always lands in the result register
   `SBSPH_ASSERT(a_adv_fills_output, clock, reset, s1_adv |=> rsp_valid_ff, "result beat lost")
   // forwarding never survives a sweep
   `SBSPH_ASSERT(a_fwd_dropped_in_sweep, clock, reset, clear_busy |=> !fwd_valid_ff,
                 "stale forward after sweep")

endmodule

`default_nettype wire
